@@ rtl/arbt_pkg.sv @@
// Package for the address range block table.
// Holds the operation codes, default table depth and the word that travels along the cell chain.
// No dependencies.
package arbt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = 32;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [1:0]        op;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic              placed;
        logic              hit;
    } word_t;

endpackage

@@ rtl/arbt_if.sv @@
// Request and response channels of the address range block table.
// Valid/ready handshake; depends on arbt_pkg for the address width.
interface arbt_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic [arbt_pkg::ADDR_W-1:0]  addr_a;
    logic [arbt_pkg::ADDR_W-1:0]  addr_b;

    modport source (output valid, output op, output addr_a, output addr_b, input ready);
    modport sink   (input valid, input op, input addr_a, input addr_b, output ready);
endinterface

interface arbt_rsp_if;
    logic valid;
    logic ready;
    logic is_blocked;
    logic status;

    modport source (output valid, output is_blocked, output status, input ready);
    modport sink   (input valid, input is_blocked, input status, output ready);
endinterface

@@ rtl/arbt_order.sv @@
// Entry stage of the cell chain: orders the range bounds and registers the word.
// Depends on arbt_pkg.
module arbt_order
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 req_valid,
    input  logic [1:0]           op,
    input  logic [arbt_pkg::ADDR_W-1:0] addr_a,
    input  logic [arbt_pkg::ADDR_W-1:0] addr_b,
    output arbt_pkg::word_t      word
);

    arbt_pkg::word_t word_reg;
    arbt_pkg::word_t word_next;
    logic            swap;

    always_comb
    begin
        swap             = addr_a > addr_b;
        word_next.valid  = req_valid;
        word_next.op     = op;
        // lookup carries its address in the low bound
        word_next.lo     = (swap && op != arbt_pkg::OP_LOOKUP) ? addr_b : addr_a;
        word_next.hi     = swap ? addr_a : addr_b;
        word_next.placed = 1'b0;
        word_next.hit    = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (advance)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

@@ rtl/arbt_cell.sv @@
// One table entry of the chain: holds a range and its valid bit, acts on the passing word.
// Depends on arbt_pkg.
module arbt_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  arbt_pkg::word_t word_in,
    output arbt_pkg::word_t word_out
);

    logic [arbt_pkg::ADDR_W-1:0] lo_reg;
    logic [arbt_pkg::ADDR_W-1:0] hi_reg;
    logic                        valid_reg;
    arbt_pkg::word_t             word_reg;
    arbt_pkg::word_t             word_next;
    logic                        claim;
    logic                        drop;
    logic                        hit;

    always_comb
    begin
        claim = word_in.valid && word_in.op == arbt_pkg::OP_ADD
                && !word_in.placed && !valid_reg;
        drop  = word_in.valid && word_in.op == arbt_pkg::OP_REMOVE && valid_reg
                && word_in.lo == lo_reg && word_in.hi == hi_reg;
        hit   = word_in.valid && word_in.op == arbt_pkg::OP_LOOKUP && valid_reg
                && word_in.lo >= lo_reg && word_in.lo <= hi_reg;
        word_next        = word_in;
        word_next.placed = word_in.placed | claim;
        word_next.hit    = word_in.hit | hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            word_reg  <= '0;
        end
        else if (advance)
        begin
            word_reg <= word_next;
            if (claim)
            begin
                valid_reg <= 1'b1;
            end
            else if (drop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && claim)
        begin
            lo_reg <= word_in.lo;
            hi_reg <= word_in.hi;
        end
    end

    assign word_out = word_reg;

endmodule

@@ rtl/address_range_block_table_core.sv @@
// A request word is registered in arbt_order and then in each cell up to the response.
// Throughput: one word per cycle; each word walks the chain one cell (table entry) a cycle.
// The whole chain stalls while a response word waits to be taken.
// Reset clears every valid bit and the chain at once; the table starts empty.
// Depends on arbt_pkg, arbt_if, arbt_order and arbt_cell.
module address_range_block_table_core
#(
    parameter int TABLE_DEPTH = arbt_pkg::TABLE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    arbt_req_if.sink   req,
    arbt_rsp_if.source rsp
);

    arbt_pkg::word_t chain [TABLE_DEPTH+1];
    arbt_pkg::word_t tail;
    logic            advance;

    assign tail    = chain[TABLE_DEPTH];
    assign advance = !tail.valid || rsp.ready;
    assign req.ready = advance;

    arbt_order u_order
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req_valid (req.valid),
        .op        (req.op),
        .addr_a    (req.addr_a),
        .addr_b    (req.addr_b),
        .word      (chain[0])
    );

    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        arbt_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .word_in  (chain[k]),
            .word_out (chain[k+1])
        );
    end

    assign rsp.valid      = tail.valid;
    assign rsp.is_blocked = tail.hit;
    assign rsp.status     = tail.op == arbt_pkg::OP_ADD && !tail.placed;

endmodule

@@ rtl/arbt_checker.sv @@
// Port checker for the address range block table, bound to the top level.
// Depends on the top level's channel ports only.
module arbt_checker
(
    input logic clk,
    input logic rst_n,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_is_blocked,
    input logic rsp_status
);

    // hold a stalled response word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response word dropped while stalled");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_is_blocked && rsp_status))
        else $error("lookup hit and full flag on one word");

    a_ready_follow: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> req_ready)
        else $error("request stalled while response side drains");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !rsp_valid)
        else $error("response word present straight after reset");

endmodule

bind address_range_block_table_core arbt_checker u_arbt_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_is_blocked (rsp.is_blocked),
    .rsp_status     (rsp.status)
);
